FILE: rtl/spu_pkg.sv
package spu_pkg;

    localparam int COORD_W   = 16;
    localparam int UV_W      = 16;
    localparam int FRAC_W    = COORD_W - 2;
    localparam int SQ_W      = 2 * COORD_W;

    localparam logic [SQ_W-1:0] UNIT_SQ  = SQ_W'(64'd1 << (2 * FRAC_W));
    localparam logic [SQ_W-1:0] NORM_MIN = SQ_W'((64'd1 << (2 * FRAC_W)) / 64'd1000000);
    localparam logic [19:0]     THR_MUL  = 20'd1000000;

    localparam int ROOT_STEPS = 31;
    localparam int ROOT_NW    = 63;
    localparam int SHIFT_W    = 46;
    localparam int ROT_STEPS  = 30;
    localparam int QUO_W      = ROT_STEPS;
    localparam int LAT_DW     = 48;
    localparam int LAT_VW     = 32;
    localparam int LON_VW     = COORD_W + 1;
    localparam int CX_W       = 44;
    localparam int CZ_W       = 34;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } spu_in_t;

    typedef struct packed {
        logic [UV_W-1:0] tex_u;
        logic [UV_W-1:0] tex_v;
    } spu_out_t;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic zneg;
        logic ypos;
        logic gt;
        logic zbig;
        logic lat_ok;
        logic lin;
    } spu_fintag_t;

    typedef struct packed {
        spu_fintag_t        fl;
        logic [QUO_W-1:0]   lon_num;
        logic [LON_VW-1:0]  lon_den;
        logic [SHIFT_W-1:0] ys;
    } spu_sqtag_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] spu_rot_angle(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            24: a = 32'h00000029;
            25: a = 32'h00000014;
            26: a = 32'h0000000A;
            27: a = 32'h00000005;
            28: a = 32'h00000003;
            29: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/sphere_to_panorama_uv_core.sv
// Sphere point to panorama texture coordinate converter.
// Input channel s_valid/s_ready/s_data carries one point (pos_x, pos_y,
// pos_z, signed Q2.14, y vertical). Output channel m_valid/m_ready/m_data
// returns tex_u and tex_v, unsigned Q0.16, one word per input word.
// Throughput: one point per clock while the output is being taken.
// Pipeline from an accepted point to m_valid: four front stages (squares,
// sums, thresholds, scaling), a 31-stage square root, one setup stage,
// 30 stages of parallel CORDIC and two restoring dividers, one result
// stage and the output register.
// Reset (aresetn low at a clock edge) empties the pipeline and the output;
// no words are in flight afterwards and no configuration is needed.
// When m_ready is low the output word holds; one more word is caught in a
// skid register, after which s_ready drops and the whole pipeline holds
// until the output is taken. Nothing is dropped or repeated.
module sphere_to_panorama_uv_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spu_pkg::spu_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output spu_pkg::spu_out_t m_data
);
    import spu_pkg::*;

    localparam int VS_W = UV_W + 3;
    localparam logic signed [VS_W-1:0] ONE_S  = VS_W'(1) << UV_W;
    localparam logic signed [VS_W-1:0] HALF_S = VS_W'(1) << (UV_W - 1);
    localparam logic signed [VS_W-1:0] TQ_S   = VS_W'(3) << (UV_W - 2);
    localparam logic signed [VS_W-1:0] MAX_S  = (VS_W'(1) << UV_W) - VS_W'(1);
    localparam logic [CX_W-4:0]        CLIP_LIM = (CX_W-3)'(1) << 40;
    localparam logic [CZ_W-1:0]        ANG_MAX  = CZ_W'(1) << 30;
    localparam logic [QUO_W-1:0]       LON_QMAX = QUO_W'(1) << (UV_W - 3);

    logic en;

    // ---------------- stage 1: magnitudes and squares
    logic              v1_reg;
    logic              xneg1_reg, yneg1_reg, zneg1_reg, ypos1_reg;
    logic [COORD_W-1:0] ax1_reg, ay1_reg, az1_reg;
    logic [SQ_W-1:0]   x2_1_reg, y2_1_reg, z2_1_reg;
    logic [COORD_W-1:0] ax_next, ay_next, az_next;

    always_comb begin
        ax_next = s_data.pos_x[COORD_W-1] ? (COORD_W'(0) - COORD_W'(s_data.pos_x))
                                          : COORD_W'(s_data.pos_x);
        ay_next = s_data.pos_y[COORD_W-1] ? (COORD_W'(0) - COORD_W'(s_data.pos_y))
                                          : COORD_W'(s_data.pos_y);
        az_next = s_data.pos_z[COORD_W-1] ? (COORD_W'(0) - COORD_W'(s_data.pos_z))
                                          : COORD_W'(s_data.pos_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xneg1_reg <= s_data.pos_x[COORD_W-1];
            yneg1_reg <= s_data.pos_y[COORD_W-1];
            zneg1_reg <= s_data.pos_z[COORD_W-1];
            ypos1_reg <= !s_data.pos_y[COORD_W-1] && (s_data.pos_y != '0);
            ax1_reg   <= ax_next;
            ay1_reg   <= ay_next;
            az1_reg   <= az_next;
            x2_1_reg  <= SQ_W'(ax_next) * SQ_W'(ax_next);
            y2_1_reg  <= SQ_W'(ay_next) * SQ_W'(ay_next);
            z2_1_reg  <= SQ_W'(az_next) * SQ_W'(az_next);
        end
    end

    // ---------------- stage 2: sums, scaled products, longitude operands
    logic               v2_reg;
    spu_fintag_t        fl2_reg;
    logic [COORD_W-1:0] ay2_reg;
    logic [SQ_W-1:0]    s2_2_reg, l2_2_reg;
    logic [SQ_W+17:0]   z2m2_reg;
    logic [SQ_W+4:0]    y100_2_reg;
    logic [QUO_W-1:0]   lnum2_reg;
    logic [LON_VW-1:0]  lden2_reg;
    logic               gt_next;
    logic [COORD_W-1:0] big_next, small_next;
    logic [SQ_W-1:0]    s2_next;

    always_comb begin
        gt_next    = ax1_reg > az1_reg;
        big_next   = gt_next ? ax1_reg : az1_reg;
        small_next = gt_next ? az1_reg : ax1_reg;
        s2_next    = x2_1_reg + z2_1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fl2_reg.xneg   <= xneg1_reg;
            fl2_reg.yneg   <= yneg1_reg;
            fl2_reg.zneg   <= zneg1_reg;
            fl2_reg.ypos   <= ypos1_reg;
            fl2_reg.gt     <= gt_next;
            fl2_reg.zbig   <= 1'b0;
            fl2_reg.lat_ok <= 1'b0;
            fl2_reg.lin    <= 1'b0;
            ay2_reg    <= ay1_reg;
            s2_2_reg   <= s2_next;
            l2_2_reg   <= s2_next + y2_1_reg;
            z2m2_reg   <= (SQ_W+18)'(z2_1_reg) * (SQ_W+18)'(THR_MUL);
            y100_2_reg <= (SQ_W+5)'(y2_1_reg) * (SQ_W+5)'(100);
            lnum2_reg  <= QUO_W'({small_next, 14'b0}) + QUO_W'(big_next);
            lden2_reg  <= {big_next, 1'b0};
        end
    end

    // ---------------- stage 3: thresholds and root prescale amount
    logic               v3_reg;
    spu_fintag_t        fl3_reg;
    logic [COORD_W-1:0] ay3_reg;
    logic [SQ_W-1:0]    s2_3_reg, scale3_reg;
    logic [SQ_W+18:0]   s2m3_reg;
    logic [SQ_W+5:0]    s49_3_reg;
    logic [SQ_W+4:0]    y100_3_reg;
    logic [4:0]         sh3_reg;
    logic [QUO_W-1:0]   lnum3_reg;
    logic [LON_VW-1:0]  lden3_reg;
    logic [SQ_W-1:0]    scale_next;
    logic [4:0]         lead_c;
    spu_fintag_t        fl3_next;

    always_comb begin
        scale_next = (l2_2_reg > NORM_MIN) ? l2_2_reg : UNIT_SQ;
        lead_c = '0;
        for (int i = 0; i < SQ_W; i++) begin
            if (s2_2_reg[i]) begin
                lead_c = 5'(i);
            end
        end
        fl3_next      = fl2_reg;
        fl3_next.zbig = z2m2_reg > (SQ_W+18)'(scale_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fl3_reg      <= fl3_next;
            ay3_reg      <= ay2_reg;
            s2_3_reg     <= s2_2_reg;
            scale3_reg   <= scale_next;
            s2m3_reg     <= (SQ_W+19)'(s2_2_reg) * (SQ_W+19)'(THR_MUL);
            s49_3_reg    <= (SQ_W+6)'(s2_2_reg) * (SQ_W+6)'(49);
            y100_3_reg   <= y100_2_reg;
            sh3_reg      <= 5'((6'd61 - {1'b0, lead_c}) >> 1);
            lnum3_reg    <= lnum2_reg;
            lden3_reg    <= lden2_reg;
        end
    end

    // ---------------- stage 4: latitude tests, shifted root operand
    logic            v4_reg;
    spu_sqtag_t      tg4_reg;
    logic [ROOT_NW-1:0] n4_reg;
    spu_fintag_t     fl4_next;

    always_comb begin
        fl4_next        = fl3_reg;
        fl4_next.lat_ok = s2m3_reg > (SQ_W+19)'(scale3_reg);
        fl4_next.lin    = (SQ_W+6)'(y100_3_reg) < s49_3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tg4_reg.fl        <= fl4_next;
            tg4_reg.lon_num   <= lnum3_reg;
            tg4_reg.lon_den   <= lden3_reg;
            tg4_reg.ys        <= SHIFT_W'(ay3_reg) << sh3_reg;
            n4_reg            <= ROOT_NW'(s2_3_reg) << {sh3_reg, 1'b0};
        end
    end

    // ---------------- square root
    logic                  rt_valid;
    logic [ROOT_STEPS-1:0] rt_root;
    spu_sqtag_t            rt_tag;

    spu_sqrt #(
        .NW    (ROOT_NW),
        .STEPS (ROOT_STEPS),
        .TW    ($bits(spu_sqtag_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_n      (n4_reg),
        .in_tag    (tg4_reg),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_tag   (rt_tag)
    );

    // ---------------- stage 5: CORDIC prescale, divider operands
    logic                  v5_reg;
    spu_fintag_t           fl5_reg;
    logic signed [CX_W-1:0] cx5_reg, cy5_reg;
    logic [QUO_W-1:0]      latn5_reg;
    logic [LAT_VW-1:0]     latr5_reg, latd5_reg;
    logic [QUO_W-1:0]      lonn5_reg;
    logic [LON_VW-1:0]     lond5_reg;
    logic [2:0]            pre_c;
    logic [LAT_DW-1:0]     latdd_c;

    always_comb begin
        pre_c = '0;
        for (int j = 0; j < 5; j++) begin
            if ((rt_tag.ys >> j) > SHIFT_W'(CLIP_LIM)) begin
                pre_c = pre_c + 3'd1;
            end
        end
        latdd_c = LAT_DW'({rt_tag.ys, 16'b0}) + LAT_DW'(rt_root);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= rt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fl5_reg   <= rt_tag.fl;
            cx5_reg   <= $signed(CX_W'(rt_root >> pre_c));
            cy5_reg   <= $signed(CX_W'(rt_tag.ys >> pre_c));
            latn5_reg <= latdd_c[QUO_W-1:0];
            latr5_reg <= LAT_VW'(latdd_c[LAT_DW-1:QUO_W]);
            latd5_reg <= {rt_root, 1'b0};
            lonn5_reg <= rt_tag.lon_num;
            lond5_reg <= rt_tag.lon_den;
        end
    end

    // ---------------- parallel CORDIC and dividers
    logic                   cd_valid;
    logic signed [CZ_W-1:0] cd_z;
    spu_fintag_t            ft;
    logic [QUO_W-1:0]       lat_quo, lon_quo;

    spu_cordic #(
        .STEPS (ROT_STEPS),
        .XW    (CX_W),
        .ZW    (CZ_W),
        .TW    ($bits(spu_fintag_t))
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_x      (cx5_reg),
        .in_y      (cy5_reg),
        .in_tag    (fl5_reg),
        .out_valid (cd_valid),
        .out_z     (cd_z),
        .out_tag   (ft)
    );

    spu_div #(
        .Q  (QUO_W),
        .VW (LAT_VW)
    ) u_lat_div (
        .aclk    (aclk),
        .en      (en),
        .in_num  (latn5_reg),
        .in_rem  (latr5_reg),
        .in_den  (latd5_reg),
        .out_quo (lat_quo)
    );

    spu_div #(
        .Q  (QUO_W),
        .VW (LON_VW)
    ) u_lon_div (
        .aclk    (aclk),
        .en      (en),
        .in_num  (lonn5_reg),
        .in_rem  ('0),
        .in_den  (lond5_reg),
        .out_quo (lon_quo)
    );

    // ---------------- stage 6: assemble and saturate
    logic              v6_reg;
    spu_out_t          res6_reg;
    logic [CZ_W-1:0]   ang_c;
    logic [CZ_W-1:0]   angr_c;
    logic [UV_W:0]     latq_c;
    logic signed [VS_W-1:0] lonq_c, sq_c, u_c, v_c;
    spu_out_t          res_next;

    always_comb begin
        if (cd_z[CZ_W-1]) begin
            ang_c = '0;
        end else if (cd_z > $signed(ANG_MAX)) begin
            ang_c = ANG_MAX;
        end else begin
            ang_c = cd_z;
        end
        angr_c = (ang_c + (CZ_W'(1) << (30 - UV_W))) >> (31 - UV_W);
        latq_c = ft.lin ? lat_quo[UV_W:0] : angr_c[UV_W:0];

        lonq_c = $signed(VS_W'(lon_quo[UV_W-3:0]));
        if (ft.gt || ft.zbig) begin
            sq_c = (ft.xneg != ft.zneg) ? -lonq_c : lonq_c;
        end else begin
            sq_c = '0;
        end
        if (ft.gt) begin
            u_c = (ft.xneg ? ONE_S : HALF_S) + sq_c;
        end else begin
            u_c = TQ_S - sq_c + (ft.zneg ? HALF_S : VS_W'(0));
        end

        if (ft.lat_ok) begin
            v_c = ft.yneg ? HALF_S - $signed(VS_W'(latq_c))
                          : HALF_S + $signed(VS_W'(latq_c));
        end else begin
            v_c = ft.ypos ? ONE_S : VS_W'(0);
        end

        // clamp to the coordinate range
        if (u_c < 0) begin
            res_next.tex_u = '0;
        end else if (u_c > MAX_S) begin
            res_next.tex_u = '1;
        end else begin
            res_next.tex_u = u_c[UV_W-1:0];
        end
        if (v_c < 0) begin
            res_next.tex_v = '0;
        end else if (v_c > MAX_S) begin
            res_next.tex_v = '1;
        end else begin
            res_next.tex_v = v_c[UV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= cd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res6_reg <= res_next;
        end
    end

    // ---------------- output register with skid
    logic     m_valid_reg, skid_valid_reg;
    spu_out_t m_data_reg, skid_data_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= v6_reg;
        end else if (v6_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (!m_valid_reg || m_ready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_data_reg <= res6_reg;
        end else begin
            skid_data_reg <= res6_reg;
        end
    end

    // ---------------- checks
    ap_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held with no output word");

    ap_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !skid_valid_reg && !v6_reg))
        else $error("words left in flight after reset");

    ap_lat_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cd_valid && ft.lat_ok && ft.lin) |-> (lat_quo[QUO_W-1:UV_W+1] == '0))
        else $error("linear latitude quotient out of range");

    ap_lon_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cd_valid && (ft.gt || ft.zbig)) |-> (lon_quo <= LON_QMAX))
        else $error("longitude quotient out of range");

endmodule

FILE: rtl/spu_sqrt.sv
module spu_sqrt #(
    parameter int NW    = 63,
    parameter int STEPS = 31,
    parameter int TW    = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NW-1:0]    in_n,
    input  logic [TW-1:0]    in_tag,
    output logic             out_valid,
    output logic [STEPS-1:0] out_root,
    output logic [TW-1:0]    out_tag
);

    logic [STEPS-1:0] v_reg;
    logic [NW-1:0]    n_reg   [STEPS];
    logic [NW-1:0]    r_reg   [STEPS];
    logic [TW-1:0]    tag_reg [STEPS];
    logic [NW-1:0]    n_in    [STEPS];
    logic [NW-1:0]    r_in    [STEPS];
    logic [NW-1:0]    n_next  [STEPS];
    logic [NW-1:0]    r_next  [STEPS];
    logic [NW-1:0]    sum_c   [STEPS];
    logic [NW-1:0]    bit_c   [STEPS];

    // one result bit per stage, largest first
    always_comb begin
        n_in[0] = in_n;
        r_in[0] = '0;
        for (int k = 1; k < STEPS; k++) begin
            n_in[k] = n_reg[k-1];
            r_in[k] = r_reg[k-1];
        end
        for (int k = 0; k < STEPS; k++) begin
            bit_c[k] = {{(NW-1){1'b0}}, 1'b1} << (2 * (STEPS - 1 - k));
            sum_c[k] = r_in[k] + bit_c[k];
            if (n_in[k] >= sum_c[k]) begin
                n_next[k] = n_in[k] - sum_c[k];
                r_next[k] = (r_in[k] >> 1) + bit_c[k];
            end else begin
                n_next[k] = n_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int k = 0; k < STEPS; k++) begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
            end
            for (int k = 1; k < STEPS; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_root  = r_reg[STEPS-1][STEPS-1:0];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

FILE: rtl/spu_div.sv
module spu_div #(
    parameter int Q  = 30,
    parameter int VW = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [Q-1:0]  in_num,
    input  logic [VW-1:0] in_rem,
    input  logic [VW-1:0] in_den,
    output logic [Q-1:0]  out_quo
);

    logic [VW-1:0] rem_reg  [Q];
    logic [VW-1:0] den_reg  [Q];
    logic [Q-1:0]  w_reg    [Q];
    logic [VW-1:0] rem_in   [Q];
    logic [VW-1:0] den_in   [Q];
    logic [Q-1:0]  w_in     [Q];
    logic [VW-1:0] rem_next [Q];
    logic [Q-1:0]  w_next   [Q];
    logic [VW:0]   t_c      [Q];

    // restoring division: shift one dividend bit in, one quotient bit out
    always_comb begin
        rem_in[0] = in_rem;
        den_in[0] = in_den;
        w_in[0]   = in_num;
        for (int k = 1; k < Q; k++) begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            w_in[k]   = w_reg[k-1];
        end
        for (int k = 0; k < Q; k++) begin
            t_c[k] = {rem_in[k], w_in[k][Q-1]};
            if (t_c[k] >= {1'b0, den_in[k]}) begin
                rem_next[k] = VW'(t_c[k] - {1'b0, den_in[k]});
                w_next[k]   = {w_in[k][Q-2:0], 1'b1};
            end else begin
                rem_next[k] = t_c[k][VW-1:0];
                w_next[k]   = {w_in[k][Q-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < Q; k++) begin
                rem_reg[k] <= rem_next[k];
                w_reg[k]   <= w_next[k];
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign out_quo = w_reg[Q-1];

endmodule

FILE: rtl/spu_cordic.sv
module spu_cordic #(
    parameter int STEPS = 30,
    parameter int XW    = 44,
    parameter int ZW    = 34,
    parameter int TW    = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  logic [TW-1:0]        in_tag,
    output logic                 out_valid,
    output logic signed [ZW-1:0] out_z,
    output logic [TW-1:0]        out_tag
);
    import spu_pkg::*;

    logic [STEPS-1:0]     v_reg;
    logic signed [XW-1:0] x_reg   [STEPS];
    logic signed [XW-1:0] y_reg   [STEPS];
    logic signed [ZW-1:0] z_reg   [STEPS];
    logic [TW-1:0]        tag_reg [STEPS];
    logic signed [XW-1:0] x_in    [STEPS];
    logic signed [XW-1:0] y_in    [STEPS];
    logic signed [ZW-1:0] z_in    [STEPS];
    logic signed [XW-1:0] x_next  [STEPS];
    logic signed [XW-1:0] y_next  [STEPS];
    logic signed [ZW-1:0] z_next  [STEPS];
    logic signed [ZW-1:0] ang_c   [STEPS];

    // vectoring mode: rotate y toward zero, accumulate the angle
    always_comb begin
        x_in[0] = in_x;
        y_in[0] = in_y;
        z_in[0] = '0;
        for (int k = 1; k < STEPS; k++) begin
            x_in[k] = x_reg[k-1];
            y_in[k] = y_reg[k-1];
            z_in[k] = z_reg[k-1];
        end
        for (int k = 0; k < STEPS; k++) begin
            ang_c[k] = $signed({{(ZW-32){1'b0}}, spu_rot_angle(k)});
            if (!y_in[k][XW-1]) begin
                x_next[k] = x_in[k] + (y_in[k] >>> k);
                y_next[k] = y_in[k] - (x_in[k] >>> k);
                z_next[k] = z_in[k] + ang_c[k];
            end else begin
                x_next[k] = x_in[k] - (y_in[k] >>> k);
                y_next[k] = y_in[k] + (x_in[k] >>> k);
                z_next[k] = z_in[k] - ang_c[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int k = 0; k < STEPS; k++) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
            for (int k = 1; k < STEPS; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_z     = z_reg[STEPS-1];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

FILE: verif/sphere_to_panorama_uv_core_test.sv
module sphere_to_panorama_uv_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spu_pkg::*;

    localparam longint ONE = 64'd1 << UV_W;
    localparam longint UVMAX = ONE - 1;
    localparam int LATENCY = 67;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    spu_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    spu_out_t m_data;

    int mismatches = 0;
    int send_idle_pct = 14;
    int recv_idle_pct = 51;
    bit gen_done = 1'b0;

    always #5 aclk = ~aclk;

    sphere_to_panorama_uv_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic longint unsigned rnd_div(longint unsigned n, longint unsigned d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint fshift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint atan_turns(longint unsigned yv, longint unsigned xv);
        longint x, y, z, dx, dy;
        z = 0;
        while (yv > (64'd1 << 40) || xv > (64'd1 << 40)) begin
            yv >>= 1;
            xv >>= 1;
        end
        x = xv;
        y = yv;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(spu_rot_angle(i));
            end else begin
                x -= dx; y += dy; z -= longint'(spu_rot_angle(i));
            end
        end
        if (z < 0) z = 0;
        if (z > (64'd1 << 30)) z = 64'd1 << 30;
        return z;
    endfunction

    function automatic longint clamp_uv(longint v);
        if (v < 0) return 0;
        return v > UVMAX ? UVMAX : v;
    endfunction

    function automatic spu_out_t project_point(spu_in_t p);
        longint x, y, z, u, v, sq, q;
        longint unsigned ax, ay, az, x2, y2, z2, l2, s2, unit, scale, thr, r, ys, uq;
        int s;
        spu_out_t o;
        x = p.pos_x;
        y = p.pos_y;
        z = p.pos_z;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        x2 = ax * ax; y2 = ay * ay; z2 = az * az;
        l2 = x2 + y2 + z2;
        s2 = x2 + z2;
        unit = 64'd1 << (2 * FRAC_W);
        scale = (l2 > unit / 1000000) ? l2 : unit;
        thr = scale / 1000000;
        if (ax > az) begin
            uq = rnd_div(az << (UV_W - 3), ax);
            sq = ((z < 0) != (x < 0)) ? -longint'(uq) : longint'(uq);
            u = (x < 0 ? ONE : ONE / 2) + sq;
        end else begin
            sq = 0;
            if (z2 > thr) begin
                uq = rnd_div(ax << (UV_W - 3), az);
                sq = ((x < 0) != (z < 0)) ? -longint'(uq) : longint'(uq);
            end
            u = 3 * (ONE / 4) - sq + (z < 0 ? ONE / 2 : 0);
        end
        if (s2 > thr) begin
            s = 0;
            while (s < 30 && s2 < (64'd1 << (60 - 2 * s))) s++;
            r = int_sqrt(s2 << (2 * s));
            ys = ay << s;
            // exact form of |y| / |xz| < 0.7
            if (100 * y2 < 49 * s2)
                q = rnd_div(ys << (UV_W - 1), r);
            else
                q = (atan_turns(ys, r) + (64'd1 << (30 - UV_W))) >>> (31 - UV_W);
            v = ONE / 2 + (y < 0 ? -q : q);
        end else begin
            v = y > 0 ? ONE : 0;
        end
        o.tex_u = UV_W'(clamp_uv(u));
        o.tex_v = UV_W'(clamp_uv(v));
        return o;
    endfunction

    class uv_scoreboard;
        spu_out_t pending_uv[$];

        function void note_point(spu_in_t p);
            pending_uv = {pending_uv, project_point(p)};
        endfunction

        task check_word(spu_out_t got);
            spu_out_t want;
            if (pending_uv.size() == 0) begin
                report_mismatch("unexpected word", got, 0);
            end else begin
                want = pending_uv.pop_front();
                if (got.tex_u !== want.tex_u) report_mismatch("tex_u", got.tex_u, want.tex_u);
                if (got.tex_v !== want.tex_v) report_mismatch("tex_v", got.tex_v, want.tex_v);
            end
        endtask
    endclass

    uv_scoreboard board = new();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_point(s_data);
            if (m_valid && m_ready) board.check_word(m_data);
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] pz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= '{pos_x: px, pos_y: py, pos_z: pz};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'($urandom_range(15)) - 16'd8;
            1: return 16'($urandom_range(400)) - 16'd200;
            2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                        : 16'h8000 + 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_points(input int n);
        logic [15:0] a, b, c;
        for (int i = 0; i < n; i++) begin
            a = rand_coord(); b = rand_coord(); c = rand_coord();
            case ($urandom_range(4))
                0: b = 16'($urandom_range(2)) * b;          // near equator or zero y
                1: begin a = 16'($urandom_range(3)) - 16'd1; c = a; end  // near pole
                2: c = a ^ 16'($urandom_range(1));          // |x| near |z|
                default: ;
            endcase
            send_point(a, b, c);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_point(16'h0000, 16'h0000, 16'h0000);
        send_point(16'h7fff, 16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h8000, 16'h7fff, 16'h0000);
        send_point(16'h0000, 16'h4000, 16'h0000);
        send_point(16'h0000, 16'hc000, 16'h0000);
        send_point(16'h0001, 16'h4000, 16'h0000);
        send_point(16'h0000, 16'h0001, 16'h0000);
        send_point(16'h4000, 16'h0000, 16'h0000);
        send_point(16'hc000, 16'h0000, 16'h0000);
        send_point(16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0000, 16'h0000, 16'hc000);
        send_point(16'h4000, 16'h0000, 16'h4000);
        send_point(16'hc000, 16'h0000, 16'h4000);
        send_point(16'h4000, 16'h0000, 16'hc000);
        send_point(16'h2000, 16'h1660, 16'h0000);
        send_point(16'h2000, 16'h1670, 16'h0000);
        send_point(16'h0001, 16'h0000, 16'hffff);
        send_point(16'h0003, 16'hfffe, 16'h0002);
        send_point(16'h1234, 16'hedcb, 16'h8001);
        send_point(16'h7fff, 16'h8000, 16'h7fff);
        // hold off until the pipeline drains
        s_valid <= 1'b0;
        while (board.pending_uv.size() != 0) @(negedge aclk);
        random_points(650);
        send_idle_pct = 51; recv_idle_pct = 14;
        random_points(650);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_points(650);
        s_valid <= 1'b0;
        while (board.pending_uv.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (mismatches == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #3ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
